// ===== sv/jsu_pkg.sv =====
// Types and codes shared by the JSON string unescaper.
package jsu_pkg;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_CONTROL   = 3'd1;
  localparam logic [2:0] ERR_ESCAPE    = 3'd2;
  localparam logic [2:0] ERR_HEX       = 3'd3;
  localparam logic [2:0] ERR_UNTERM    = 3'd4;
  localparam logic [2:0] ERR_NO_QUOTE  = 3'd5;

  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_U         = 8'h75;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last;
  } result_t;

endpackage

// ===== sv/json_string_unescaper.sv =====
// Top level of the JSON string unescaper: byte decoder and result queue.

// One raw byte is taken per transfer and decoded in the same cycle into zero
// to three results, which enter a four-entry result queue; results leave the
// queue one per cycle while out_stall_i is low. A string of plain bytes and
// simple escapes sustains one byte per cycle while the output is not stalled.
// A \u escape that encodes to two or three UTF-8 bytes can hold the input,
// because the input is stalled whenever the queue holds more than one result.
// There is no clearing pass after reset.
module json_string_unescaper
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic [2:0] error_code_o,
  output logic       last_o
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  logic [1:0]  mode_q, mode_d;
  logic [11:0] hex_accum_q, hex_accum_d;
  logic [1:0]  hex_count_q, hex_count_d;

  result_t     queue_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  count_q, count_d;

  result_t     res [3];
  logic [1:0]  num_res;
  logic        in_xfer, out_xfer;
  logic        hex_ok;
  logic [3:0]  hex_nib;
  logic [15:0] code_point;
  logic [7:0]  esc_byte;
  logic        esc_ok;

  function automatic result_t make_res(logic [7:0] b, logic [1:0] k, logic [2:0] e);
    result_t r;
    r.out_byte   = b;
    r.kind       = k;
    r.error_code = e;
    r.last       = 1'b0;
    return r;
  endfunction

  assign in_stall_o  = (count_q > 3'd1);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != 3'd0);
  assign out_xfer    = out_valid_o && !out_stall_i;

  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'd0;
    if (data_byte_i >= 8'h30 && data_byte_i <= 8'h39) begin
      hex_nib = data_byte_i[3:0];
    end else if ((data_byte_i >= 8'h41 && data_byte_i <= 8'h46) ||
                 (data_byte_i >= 8'h61 && data_byte_i <= 8'h66)) begin
      hex_nib = data_byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = data_byte_i;
    unique case (data_byte_i)
      CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: esc_byte = data_byte_i;
      8'h62:   esc_byte = 8'h08;
      8'h66:   esc_byte = 8'h0C;
      8'h6E:   esc_byte = 8'h0A;
      8'h72:   esc_byte = 8'h0D;
      8'h74:   esc_byte = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  assign code_point = {hex_accum_q, hex_nib};

  always_comb begin
    mode_d      = mode_q;
    hex_accum_d = hex_accum_q;
    hex_count_d = hex_count_q;
    num_res     = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res[k] = make_res(8'h00, KIND_BYTE, ERR_NONE);
    end
    unique case (mode_q)
      MODE_STR: begin
        if (end_of_data_i) begin
          res[0]  = make_res(8'h00, KIND_ERROR, ERR_UNTERM);
          num_res = 2'd1;
        end else if (data_byte_i == CHAR_QUOTE) begin
          res[0]  = make_res(8'h00, KIND_DONE, ERR_NONE);
          num_res = 2'd1;
        end else if (data_byte_i < CHAR_SPACE) begin
          res[0]  = make_res(8'h00, KIND_ERROR, ERR_CONTROL);
          num_res = 2'd1;
        end else if (data_byte_i == CHAR_BACKSLASH) begin
          mode_d = MODE_ESC;
        end else begin
          res[0]  = make_res(data_byte_i, KIND_BYTE, ERR_NONE);
          num_res = 2'd1;
        end
        if (num_res != 2'd0 && res[0].kind != KIND_BYTE) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_ESC: begin
        if (!end_of_data_i && data_byte_i == CHAR_U) begin
          mode_d      = MODE_HEX;
          hex_accum_d = 12'd0;
          hex_count_d = 2'd0;
        end else if (!end_of_data_i && esc_ok) begin
          mode_d  = MODE_STR;
          res[0]  = make_res(esc_byte, KIND_BYTE, ERR_NONE);
          num_res = 2'd1;
        end else begin
          mode_d  = MODE_IDLE;
          res[0]  = make_res(8'h00, KIND_ERROR, ERR_ESCAPE);
          num_res = 2'd1;
        end
      end
      MODE_HEX: begin
        if (end_of_data_i || !hex_ok) begin
          mode_d      = MODE_IDLE;
          hex_accum_d = 12'd0;
          hex_count_d = 2'd0;
          res[0]      = make_res(8'h00, KIND_ERROR, ERR_HEX);
          num_res     = 2'd1;
        end else if (hex_count_q == 2'd3) begin
          mode_d      = MODE_STR;
          hex_accum_d = 12'd0;
          hex_count_d = 2'd0;
          if (code_point[15:7] == 9'd0) begin
            res[0]  = make_res({1'b0, code_point[6:0]}, KIND_BYTE, ERR_NONE);
            num_res = 2'd1;
          end else if (code_point[15:11] == 5'd0) begin
            res[0]  = make_res({3'b110, code_point[10:6]}, KIND_BYTE, ERR_NONE);
            res[1]  = make_res({2'b10, code_point[5:0]}, KIND_BYTE, ERR_NONE);
            num_res = 2'd2;
          end else begin
            res[0]  = make_res({4'b1110, code_point[15:12]}, KIND_BYTE, ERR_NONE);
            res[1]  = make_res({2'b10, code_point[11:6]}, KIND_BYTE, ERR_NONE);
            res[2]  = make_res({2'b10, code_point[5:0]}, KIND_BYTE, ERR_NONE);
            num_res = 2'd3;
          end
        end else begin
          hex_accum_d = {hex_accum_q[7:0], hex_nib};
          hex_count_d = hex_count_q + 2'd1;
        end
      end
      default: begin
        hex_accum_d = 12'd0;
        hex_count_d = 2'd0;
        mode_d      = MODE_IDLE;
        if (!end_of_data_i) begin
          if (data_byte_i == CHAR_QUOTE) begin
            mode_d = MODE_STR;
          end else begin
            res[0]  = make_res(8'h00, KIND_ERROR, ERR_NO_QUOTE);
            num_res = 2'd1;
          end
        end
      end
    endcase
    if (num_res != 2'd0) begin
      res[num_res - 2'd1].last = 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (in_xfer) begin
      count_d = count_d + {1'b0, num_res};
    end
    if (out_xfer) begin
      count_d = count_d - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      hex_accum_q <= 12'd0;
      hex_count_q <= 2'd0;
      wr_ptr_q    <= 2'd0;
      rd_ptr_q    <= 2'd0;
      count_q     <= 3'd0;
    end else begin
      if (in_xfer) begin
        mode_q      <= mode_d;
        hex_accum_q <= hex_accum_d;
        hex_count_q <= hex_count_d;
        wr_ptr_q    <= wr_ptr_q + num_res;
      end
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(num_res)) begin
          queue_q[wr_ptr_q + 2'(k)] <= res[k];
        end
      end
    end
  end

  assign out_byte_o   = queue_q[rd_ptr_q].out_byte;
  assign kind_o       = queue_q[rd_ptr_q].kind;
  assign error_code_o = queue_q[rd_ptr_q].error_code;
  assign last_o       = queue_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4)
    else $error("Result queue holds more than four entries.");

  a_error_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == KIND_ERROR) == (error_code_o != ERR_NONE)))
    else $error("Error code does not match result kind.");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_BYTE) |-> (out_byte_o == 8'h00))
    else $error("Nonzero byte on a completion or error result.");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[1:0])
    else $error("Queue pointers disagree with the fill count.");
`endif

endmodule

// ===== dv/jsu_stream_checker.sv =====
// Checker for the JSON string unescaper: predicts decoded results and compares every transfer.
module jsu_stream_checker
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic [1:0] kind_i,
  input  logic [2:0] error_code_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {ST_IDLE, ST_TEXT, ST_ESCAPE, ST_UNICODE} str_mode_e;

  str_mode_e   str_mode;
  logic [15:0] code_acc;
  logic [1:0]  digit_cnt;
  result_t     decoded_q[$];
  result_t     want_r;
  result_t     got_r;
  int          mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic result_t make_result(logic [7:0] b, logic [1:0] k, logic [2:0] e);
    result_t r;
    r.out_byte   = b;
    r.kind       = k;
    r.error_code = e;
    r.last       = 1'b0;
    return r;
  endfunction

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic void decode_byte(logic [7:0] c, logic eod);
    result_t     res[$];
    logic [2:0]  err;
    logic [4:0]  digit;
    logic [15:0] cp;
    logic [7:0]  esc;
    err = ERR_NONE;
    esc = 8'h00;
    case (str_mode)
      ST_TEXT: begin
        if (eod) err = ERR_UNTERM;
        else if (c == CHAR_QUOTE) begin
          res = {res, make_result(8'h00, KIND_DONE, ERR_NONE)};
          str_mode = ST_IDLE;
        end else if (c < CHAR_SPACE) err = ERR_CONTROL;
        else if (c == CHAR_BACKSLASH) str_mode = ST_ESCAPE;
        else res = {res, make_result(c, KIND_BYTE, ERR_NONE)};
      end
      ST_ESCAPE: begin
        if (eod) err = ERR_ESCAPE;
        else if (c == CHAR_U) begin
          str_mode  = ST_UNICODE;
          code_acc  = '0;
          digit_cnt = '0;
        end else begin
          case (c)
            CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: esc = c;
            "b": esc = 8'h08;
            "f": esc = 8'h0C;
            "n": esc = 8'h0A;
            "r": esc = 8'h0D;
            "t": esc = 8'h09;
            default: err = ERR_ESCAPE;
          endcase
          if (err == ERR_NONE) begin
            res = {res, make_result(esc, KIND_BYTE, ERR_NONE)};
            str_mode = ST_TEXT;
          end
        end
      end
      ST_UNICODE: begin
        digit = hex_digit(c);
        if (eod || digit[4]) err = ERR_HEX;
        else begin
          cp = {code_acc[11:0], digit[3:0]};
          if (digit_cnt == 2'd3) begin
            if (cp < 16'h0080) begin
              res = {res, make_result(cp[7:0], KIND_BYTE, ERR_NONE)};
            end else if (cp < 16'h0800) begin
              res = {res, make_result({3'b110, cp[10:6]}, KIND_BYTE, ERR_NONE)};
              res = {res, make_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE)};
            end else begin
              res = {res, make_result({4'b1110, cp[15:12]}, KIND_BYTE, ERR_NONE)};
              res = {res, make_result({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE)};
              res = {res, make_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE)};
            end
            str_mode  = ST_TEXT;
            code_acc  = '0;
            digit_cnt = '0;
          end else begin
            code_acc  = cp;
            digit_cnt = digit_cnt + 2'd1;
          end
        end
      end
      default: begin
        if (!eod) begin
          if (c == CHAR_QUOTE) str_mode = ST_TEXT;
          else err = ERR_NO_QUOTE;
        end
      end
    endcase
    if (err != ERR_NONE) begin
      res = {res, make_result(8'h00, KIND_ERROR, err)};
      str_mode  = ST_IDLE;
      code_acc  = '0;
      digit_cnt = '0;
    end
    if (res.size() != 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) decoded_q = {decoded_q, res[i]};
  endfunction

  task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_mode  = ST_IDLE;
      code_acc  = '0;
      digit_cnt = '0;
      decoded_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) decode_byte(data_byte_i, end_of_data_i);
      if (out_valid_i && !out_stall_i) begin
        got_r = {out_byte_i, kind_i, error_code_i, last_i};
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, got byte %0h kind %0h code %0h last %0h",
                   $time, got_r.out_byte, got_r.kind, got_r.error_code, got_r.last);
          mismatches++;
        end else begin
          want_r = decoded_q.pop_front();
          if (got_r.out_byte !== want_r.out_byte)
            report_field("out_byte", want_r.out_byte, got_r.out_byte);
          if (got_r.kind !== want_r.kind)
            report_field("kind", 8'(want_r.kind), 8'(got_r.kind));
          if (got_r.error_code !== want_r.error_code)
            report_field("error_code", 8'(want_r.error_code), 8'(got_r.error_code));
          if (got_r.last !== want_r.last)
            report_field("last", 8'(want_r.last), 8'(got_r.last));
        end
      end
    end
    pending_o    <= decoded_q.size();
    fail_count_o <= mismatches;
  end

endmodule

// ===== dv/tb.sv =====
// Top of the JSON string unescaper testbench: clock, reset, byte stimulus and verdict.
module tb
  import jsu_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          PHASE_ITEMS  = 115;
  localparam int          LONG_HOLD    = 80;
  localparam int          TAIL_CYCLES  = 8;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       end_of_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic [1:0] kind_o;
  logic [2:0] error_code_o;
  logic       last_o;

  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles = 0;
  int          items_sent = 0;
  int unsigned cycles_run = 0;
  string       escape_chars = "\"\\/bfnrt";

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycles_run <= cycles_run + 1;

  json_string_unescaper u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .end_of_data_i(end_of_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

  jsu_stream_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .end_of_data_i(end_of_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_i   (out_byte_o),
    .kind_i       (kind_o),
    .error_code_i (error_code_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // The long hold is counted down here while the sender keeps offering bytes.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eod);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    end_of_data_i <= eod;
    do @(posedge clk_i); while (in_stall_o);
    if (!eod) items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  task automatic send_unicode(input logic [15:0] cp);
    send_byte(CHAR_BACKSLASH, 1'b0);
    send_byte(CHAR_U, 1'b0);
    for (int i = 3; i >= 0; i--) send_byte(hex_char(cp[i*4 +: 4]), 1'b0);
  endtask

  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hFFFF));
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(CHAR_SPACE, 8'hFF));
    if (c == CHAR_QUOTE || c == CHAR_BACKSLASH) c = 8'h41;
    return c;
  endfunction

  task automatic send_random_unit();
    int sel;
    if ($urandom_range(99) < 78) begin
      send_byte(CHAR_QUOTE, 1'b0);
      repeat ($urandom_range(8)) begin
        sel = $urandom_range(9);
        if (sel < 5) begin
          send_byte(plain_char(), 1'b0);
        end else if (sel < 7) begin
          send_byte(CHAR_BACKSLASH, 1'b0);
          send_byte(escape_chars[$urandom_range(7)], 1'b0);
        end else begin
          send_unicode(pick_code_point());
        end
      end
      case ($urandom_range(19))
        0: send_byte(8'($urandom_range(8'h1F)), 1'b0);
        1: begin
          send_byte(CHAR_BACKSLASH, 1'b0);
          if ($urandom_range(1)) send_byte(8'($urandom_range(8'h21)), 1'b0);
          else send_byte(8'($urandom_range(8'h76, 8'hFF)), 1'b0);
        end
        2: begin
          send_byte(CHAR_BACKSLASH, 1'b0);
          send_byte(CHAR_U, 1'b0);
          repeat ($urandom_range(3)) send_byte(hex_char(4'($urandom)), 1'b0);
          if ($urandom_range(1)) begin
            if ($urandom_range(1)) send_byte(8'($urandom_range(8'h67, 8'hFF)), 1'b0);
            else send_byte(8'($urandom_range(8'h2F)), 1'b0);
          end else begin
            send_byte(8'($urandom), 1'b1);
          end
        end
        3: send_byte(8'($urandom), 1'b1);
        default: send_byte(CHAR_QUOTE, 1'b0);
      endcase
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(9) == 0);
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) send_random_unit();
  endtask

  initial begin
    wait (cycles_run >= CYCLE_LIMIT);
    $display("tb: errors");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    data_byte_i    = 8'h00;
    end_of_data_i  = 1'b0;
    send_idle_pct  = 33;
    recv_stall_pct = 72;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_byte("x", 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(CHAR_QUOTE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(CHAR_QUOTE, 1'b0);
    send_byte(CHAR_BACKSLASH, 1'b0);
    send_byte("q", 1'b0);
    send_byte(CHAR_QUOTE, 1'b0);
    send_byte(CHAR_BACKSLASH, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(CHAR_QUOTE, 1'b0);
    send_unicode(16'hFFFF);
    send_byte(CHAR_QUOTE, 1'b0);
    send_byte(CHAR_QUOTE, 1'b0);
    send_byte(CHAR_BACKSLASH, 1'b0);
    send_byte(CHAR_U, 1'b0);
    send_byte("g", 1'b0);
    send_byte(CHAR_QUOTE, 1'b0);
    send_byte(8'hA5, 1'b1);

    run_random(PHASE_ITEMS);

    send_idle_pct  = 72;
    recv_stall_pct = 33;
    run_random(PHASE_ITEMS);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = LONG_HOLD;
    send_byte(CHAR_QUOTE, 1'b0);
    repeat (6) send_unicode(16'hFFFF);
    send_byte(CHAR_QUOTE, 1'b0);
    run_random(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
